/* design/cnm_pkg.sv */
package cnm_pkg;

  localparam int MAX_NODES_DEF  = 1024;
  localparam int COORD_BITS_DEF = 32;

  localparam int TOL_W   = 31;
  localparam int COORD_W = 32;
  localparam int END_W   = 10;
  localparam int INDEX_W = 10;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_NODE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [END_W-1:0]          end_a;
    logic [END_W-1:0]          end_b;
  } in_beat_t;

  typedef struct packed {
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] second_index;
    logic               was_merged;
    logic               keep_edge;
    logic               error;
  } out_beat_t;

endpackage

/* design/cnm_ram.sv */
module cnm_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/cnm_cell.sv */
module cnm_cell #(
  parameter int COORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  shift,
  input  logic                  wrap,
  input  logic                  load,
  input  logic [COORD_BITS-1:0] next_x,
  input  logic [COORD_BITS-1:0] next_y,
  input  logic [COORD_BITS-1:0] head_x,
  input  logic [COORD_BITS-1:0] head_y,
  input  logic [COORD_BITS-1:0] new_x,
  input  logic [COORD_BITS-1:0] new_y,
  output logic [COORD_BITS-1:0] x,
  output logic [COORD_BITS-1:0] y
);

  always_ff @(posedge clk) begin
    if (load) begin
      x <= new_x;
      y <= new_y;
    end else if (shift) begin
      x <= wrap ? head_x : next_x;
      y <= wrap ? head_y : next_y;
    end
  end

endmodule

/* design/cnm_dist.sv */
module cnm_dist #(
  parameter int COORD_BITS = 32,
  parameter int TAG_W      = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    issue,
  input  logic [TAG_W-1:0]        issue_tag,
  input  logic [COORD_BITS-1:0]   node_x,
  input  logic [COORD_BITS-1:0]   node_y,
  input  logic [COORD_BITS-1:0]   surv_x,
  input  logic [COORD_BITS-1:0]   surv_y,
  input  logic [cnm_pkg::TOL_W-1:0]   tol,
  input  logic [2*cnm_pkg::TOL_W-1:0] tol_sq,
  output logic                    hit_valid,
  output logic                    hit,
  output logic [TAG_W-1:0]        hit_tag
);
  import cnm_pkg::*;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int CMP_W  = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;

  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic [DIFF_W-1:0]        mag_x, mag_y;
  logic [DIFF_W+TOL_W-1:0]  ext_x, ext_y, ext_tol;
  logic                     near_c;

  logic                     s1_valid, s1_near;
  logic [TAG_W-1:0]         s1_tag;
  logic [TOL_W-1:0]         s1_dx, s1_dy;
  logic                     s2_valid, s2_near;
  logic [TAG_W-1:0]         s2_tag;
  logic [2*TOL_W-1:0]       s2_sqx, s2_sqy;
  logic [2*TOL_W:0]         sum_sq;

  always_comb begin
    diff_x  = $signed({node_x[COORD_BITS-1], node_x}) - $signed({surv_x[COORD_BITS-1], surv_x});
    diff_y  = $signed({node_y[COORD_BITS-1], node_y}) - $signed({surv_y[COORD_BITS-1], surv_y});
    mag_x   = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
    mag_y   = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
    ext_x   = {{TOL_W{1'b0}}, mag_x};
    ext_y   = {{TOL_W{1'b0}}, mag_y};
    ext_tol = {{DIFF_W{1'b0}}, tol};
    near_c  = (ext_x[CMP_W-1:0] < ext_tol[CMP_W-1:0]) &&
              (ext_y[CMP_W-1:0] < ext_tol[CMP_W-1:0]);
    sum_sq  = {1'b0, s2_sqx} + {1'b0, s2_sqy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      hit_valid <= 1'b0;
    end else begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      hit_valid <= s2_valid;
    end
    s1_near <= near_c;
    s1_tag  <= issue_tag;
    s1_dx   <= ext_x[TOL_W-1:0];
    s1_dy   <= ext_y[TOL_W-1:0];
    s2_near <= s1_near;
    s2_tag  <= s1_tag;
    s2_sqx  <= s1_dx * s1_dx;
    s2_sqy  <= s1_dy * s1_dy;
    hit     <= s2_near && (sum_sq < {1'b0, tol_sq});
    hit_tag <= s2_tag;
  end

endmodule

/* design/coincident_node_merge.sv */
// Coincident node merge. Survivor coordinates sit in a ring of cells that
// rotates past one pipelined distance unit, so a node load scans every stored
// survivor before it commits (it goes straight to commit when merging is off
// or no survivor is stored yet); the ring rotates one survivor per cycle into
// the three-stage distance pipeline, and the first hit in index order is the
// merge target. An edge remap makes two reads of the index map through its
// single read port. Clear, unknown kinds and rejected beats go straight to the
// finish state. A stalled result holds the block until it is taken. One item
// is worked at a time; a finished result waits in the output register while
// the next beat is taken. Stores need no clearing pass.
module coincident_node_merge #(
  parameter int MAX_NODES  = cnm_pkg::MAX_NODES_DEF,
  parameter int COORD_BITS = cnm_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cnm_pkg::in_beat_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cnm_pkg::out_beat_t         out_data,
  input  logic                       cfg_we,
  input  logic [cnm_pkg::TOL_W-1:0]  cfg_wdata
);
  import cnm_pkg::*;

  localparam int LAT    = 3;
  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int SCAN_W = $clog2(MAX_NODES + LAT + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_RD_A   = 3'd3;
  localparam logic [2:0] ST_RD_B   = 3'd4;
  localparam logic [2:0] ST_RD_END = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  localparam out_beat_t REJECT_BEAT = '{first_index: '0, second_index: '0,
                                        was_merged: 1'b0, keep_edge: 1'b0,
                                        error: 1'b1};

  logic [2:0]            state;
  logic [TOL_W-1:0]      tol;
  logic [2*TOL_W-1:0]    tol_sq;
  logic [CNT_W-1:0]      loaded_count, survivor_count;
  logic [COORD_BITS-1:0] node_x, node_y;
  logic [IDX_W-1:0]      addr_a, addr_b, first_map;
  logic [SCAN_W-1:0]     scan_cnt;
  logic                  found;
  logic [IDX_W-1:0]      found_idx;
  out_beat_t             result;

  logic                  accept, shift, load, issue, finish_go;
  logic                  hit_valid, hit;
  logic [IDX_W-1:0]      hit_tag;
  logic                  map_we;
  logic [IDX_W-1:0]      map_waddr, map_wdata, map_raddr, map_rdata;

  logic [COORD_BITS+COORD_W-1:0] ext_cx, ext_cy;
  logic [CNT_W+END_W-1:0]        ea_ext, eb_ext, lc_ext;
  logic [IDX_W+END_W-1:0]        ea_idx, eb_idx;
  logic [IDX_W+INDEX_W-1:0]      found_out, map_out, first_out;
  logic [CNT_W+INDEX_W-1:0]      new_out;
  logic [SCAN_W-1:0]             count_scan;

  logic [COORD_BITS-1:0] cx [MAX_NODES];
  logic [COORD_BITS-1:0] cy [MAX_NODES];

  always_comb begin
    accept     = in_valid && !in_stall;
    ext_cx     = {{COORD_BITS{in_data.coord_x[COORD_W-1]}}, in_data.coord_x};
    ext_cy     = {{COORD_BITS{in_data.coord_y[COORD_W-1]}}, in_data.coord_y};
    ea_ext     = {{CNT_W{1'b0}}, in_data.end_a};
    eb_ext     = {{CNT_W{1'b0}}, in_data.end_b};
    lc_ext     = {{END_W{1'b0}}, loaded_count};
    ea_idx     = {{IDX_W{1'b0}}, in_data.end_a};
    eb_idx     = {{IDX_W{1'b0}}, in_data.end_b};
    found_out  = {{INDEX_W{1'b0}}, found_idx};
    map_out    = {{INDEX_W{1'b0}}, map_rdata};
    first_out  = {{INDEX_W{1'b0}}, first_map};
    new_out    = {{INDEX_W{1'b0}}, survivor_count};
    count_scan = SCAN_W'(survivor_count);
    shift      = (state == ST_SCAN) && (scan_cnt < count_scan);
    issue      = shift;
    load       = (state == ST_COMMIT) && !found;
    map_we     = (state == ST_COMMIT);
    map_waddr  = loaded_count[IDX_W-1:0];
    map_wdata  = found ? found_idx : survivor_count[IDX_W-1:0];
    map_raddr  = (state == ST_RD_A) ? addr_a : addr_b;
    in_stall   = (state != ST_IDLE);
    finish_go  = (state == ST_FINISH) && (!out_valid || !out_stall);
  end

  for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
    cnm_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk    (clk),
      .shift  (shift),
      .wrap   (survivor_count == CNT_W'(k + 1)),
      .load   (load && (survivor_count == CNT_W'(k))),
      .next_x (cx[(k + 1) % MAX_NODES]),
      .next_y (cy[(k + 1) % MAX_NODES]),
      .head_x (cx[0]),
      .head_y (cy[0]),
      .new_x  (node_x),
      .new_y  (node_y),
      .x      (cx[k]),
      .y      (cy[k])
    );
  end

  cnm_dist #(.COORD_BITS(COORD_BITS), .TAG_W(IDX_W)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .issue_tag (scan_cnt[IDX_W-1:0]),
    .node_x    (node_x),
    .node_y    (node_y),
    .surv_x    (cx[0]),
    .surv_y    (cy[0]),
    .tol       (tol),
    .tol_sq    (tol_sq),
    .hit_valid (hit_valid),
    .hit       (hit),
    .hit_tag   (hit_tag)
  );

  cnm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    tol_sq <= tol * tol;
    if (rst) begin
      state          <= ST_IDLE;
      tol            <= '0;
      loaded_count   <= '0;
      survivor_count <= '0;
      out_valid      <= 1'b0;
      found          <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol <= cfg_wdata;
      end
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            found    <= 1'b0;
            scan_cnt <= '0;
            node_x   <= ext_cx[COORD_BITS-1:0];
            node_y   <= ext_cy[COORD_BITS-1:0];
            addr_a   <= ea_idx[IDX_W-1:0];
            addr_b   <= eb_idx[IDX_W-1:0];
            case (in_data.kind)
              KIND_NODE: begin
                if (loaded_count == CNT_W'(MAX_NODES)) begin
                  result <= REJECT_BEAT;
                  state  <= ST_FINISH;
                end else if (tol == '0 || survivor_count == '0) begin
                  result <= '0;
                  state  <= ST_COMMIT;
                end else begin
                  result <= '0;
                  state  <= ST_SCAN;
                end
              end
              KIND_EDGE: begin
                if (ea_ext >= lc_ext || eb_ext >= lc_ext) begin
                  result <= REJECT_BEAT;
                  state  <= ST_FINISH;
                end else begin
                  result <= '0;
                  state  <= ST_RD_A;
                end
              end
              KIND_CLEAR: begin
                result         <= '0;
                loaded_count   <= '0;
                survivor_count <= '0;
                state          <= ST_FINISH;
              end
              default: begin
                result <= '0;
                state  <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (hit_valid && hit && !found) begin
            found     <= 1'b1;
            found_idx <= hit_tag;
          end
          if (scan_cnt == count_scan + SCAN_W'(LAT)) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          loaded_count <= loaded_count + 1'b1;
          if (found) begin
            result.first_index <= found_out[INDEX_W-1:0];
            result.was_merged  <= 1'b1;
          end else begin
            result.first_index <= new_out[INDEX_W-1:0];
            survivor_count     <= survivor_count + 1'b1;
          end
          state <= ST_FINISH;
        end
        ST_RD_A: begin
          state <= ST_RD_B;
        end
        ST_RD_B: begin
          first_map <= map_rdata;
          state     <= ST_RD_END;
        end
        ST_RD_END: begin
          result.first_index  <= first_out[INDEX_W-1:0];
          result.second_index <= map_out[INDEX_W-1:0];
          result.keep_edge    <= (first_map != map_rdata) || (tol == '0);
          state               <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish_go) begin
            out_data <= result;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* dv/coincident_node_merge_test.sv */
module coincident_node_merge_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cnm_pkg::*;

  localparam int NODE_CAP    = 1024;
  localparam int CYCLE_LIMIT = 10_000_000;

  class node_merge_board;
    logic signed [COORD_W-1:0] surv_x[NODE_CAP];
    logic signed [COORD_W-1:0] surv_y[NODE_CAP];
    logic [INDEX_W-1:0]        node_map[NODE_CAP];
    int                        loaded;
    int                        survivors;
    logic [TOL_W-1:0]          tolerance;
    out_beat_t                 expected_q[$];
    int                        mismatches;
    int                        merges, rejects, edges_kept, edges_dropped, beats_seen;

    function bit near(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y, int k);
      longint     ddx, ddy;
      logic [63:0] ax, ay, tol64;
      ddx = longint'(x) - longint'(surv_x[k]);
      ddy = longint'(y) - longint'(surv_y[k]);
      ax = (ddx < 0) ? -ddx : ddx;
      ay = (ddy < 0) ? -ddy : ddy;
      tol64 = {33'd0, tolerance};
      if (ax >= tol64 || ay >= tol64) return 0;
      return (ax * ax + ay * ay) < (tol64 * tol64);
    endfunction

    function void note_beat(in_beat_t b);
      out_beat_t r;
      int        hit;
      r = '0;
      case (b.kind)
        KIND_NODE: begin
          if (loaded >= NODE_CAP) begin
            r.error = 1;
          end else begin
            hit = survivors;
            if (tolerance != 0)
              for (int k = 0; k < survivors; k++)
                if (near(b.coord_x, b.coord_y, k)) begin
                  hit = k;
                  break;
                end
            if (hit < survivors) begin
              r.was_merged = 1;
            end else begin
              surv_x[survivors] = b.coord_x;
              surv_y[survivors] = b.coord_y;
              survivors++;
            end
            node_map[loaded] = hit[INDEX_W-1:0];
            loaded++;
            r.first_index = hit[INDEX_W-1:0];
          end
        end
        KIND_EDGE: begin
          if (b.end_a >= loaded || b.end_b >= loaded) begin
            r.error = 1;
          end else begin
            r.first_index  = node_map[b.end_a];
            r.second_index = node_map[b.end_b];
            r.keep_edge    = (r.first_index != r.second_index) || (tolerance == 0);
          end
        end
        KIND_CLEAR: begin
          loaded = 0;
          survivors = 0;
        end
        default: ;
      endcase
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      beats_seen++;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.first_index !== want.first_index) begin
        $error("first_index: expected %0d, actual %0d", want.first_index, got.first_index);
        mismatches++;
      end
      if (got.second_index !== want.second_index) begin
        $error("second_index: expected %0d, actual %0d", want.second_index, got.second_index);
        mismatches++;
      end
      if (got.was_merged !== want.was_merged) begin
        $error("was_merged: expected %0d, actual %0d", want.was_merged, got.was_merged);
        mismatches++;
      end
      if (got.keep_edge !== want.keep_edge) begin
        $error("keep_edge: expected %0d, actual %0d", want.keep_edge, got.keep_edge);
        mismatches++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %0d, actual %0d", want.error, got.error);
        mismatches++;
      end
      merges        += want.was_merged;
      rejects       += want.error;
      edges_kept    += want.keep_edge;
      edges_dropped += (want.first_index != want.second_index || want.error) ? 0 :
                       (want.second_index == want.first_index && !want.keep_edge &&
                        want.first_index == want.second_index && !want.was_merged) ? 1 : 0;
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_beat_t        out_data;
  logic             cfg_we;
  logic [TOL_W-1:0] cfg_wdata;

  node_merge_board sb = new();
  bit              calm;
  int              cycles = 0;
  logic signed [COORD_W-1:0] centre_x[6];
  logic signed [COORD_W-1:0] centre_y[6];

  coincident_node_merge dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_beat(out_data);
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 37);
    end
  end

  task automatic send_beat(in_beat_t b);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_beat(b);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] v);
    drain();
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.tolerance = v;
    cfg_we <= 0;
  endtask

  function automatic in_beat_t noise_beat(logic [KIND_W-1:0] k);
    in_beat_t b;
    b.kind    = k;
    b.coord_x = $urandom;
    b.coord_y = $urandom;
    b.end_a   = $urandom;
    b.end_b   = $urandom;
    return b;
  endfunction

  function automatic in_beat_t node_at(longint x, longint y);
    in_beat_t b;
    b = noise_beat(KIND_NODE);
    b.coord_x = x[COORD_W-1:0];
    b.coord_y = y[COORD_W-1:0];
    return b;
  endfunction

  function automatic in_beat_t edge_of(int a, int e);
    in_beat_t b;
    b = noise_beat(KIND_EDGE);
    b.end_a = a[END_W-1:0];
    b.end_b = e[END_W-1:0];
    return b;
  endfunction

  function automatic longint jitter();
    longint r;
    r = (sb.tolerance == 0) ? 3 : longint'(sb.tolerance) + longint'(sb.tolerance) / 4;
    if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
    r = longint'($urandom_range(0, r[31:0]));
    return $urandom_range(0, 1) ? r : -r;
  endfunction

  task automatic run_phase(logic [TOL_W-1:0] tol, int count);
    int       c, pick;
    in_beat_t b;
    write_tolerance(tol);
    foreach (centre_x[i]) begin
      centre_x[i] = $urandom;
      centre_y[i] = $urandom;
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (sb.survivors > 40 || pick < 5) begin
        b = noise_beat(KIND_CLEAR);
      end else if (pick < 9) begin
        b = noise_beat(KIND_SPARE);
      end else if (pick < 15) begin
        b = noise_beat(KIND_NODE);
      end else if (pick < 60) begin
        c = $urandom_range(0, 5);
        b = node_at(longint'(centre_x[c]) + jitter(), longint'(centre_y[c]) + jitter());
      end else if (pick < 92 && sb.loaded > 0) begin
        b = edge_of($urandom_range(0, sb.loaded - 1), $urandom_range(0, sb.loaded - 1));
      end else begin
        b = noise_beat(KIND_EDGE);
      end
      send_beat(b);
    end
  endtask

  initial begin
    rst       = 1;
    in_valid  = 0;
    in_data   = '0;
    cfg_we    = 0;
    cfg_wdata = '0;
    calm      = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    sb.tolerance = '0;

    send_beat(node_at(0, 0));
    send_beat(node_at(0, 0));
    send_beat(edge_of(0, 1));
    send_beat(edge_of(0, 0));
    send_beat(edge_of(5, 0));
    send_beat(edge_of(0, 1023));
    send_beat(noise_beat(KIND_SPARE));
    send_beat(noise_beat(KIND_CLEAR));
    send_beat(edge_of(0, 0));

    write_tolerance(TOL_W'(32'h0001_0000));
    send_beat(node_at(0, 0));
    send_beat(node_at(32'h0000_FFFF, 0));
    send_beat(node_at(32'h0001_0000, 0));
    send_beat(node_at(32'h0000_B504, 32'h0000_B504));
    send_beat(node_at(32'h0000_B505, 32'h0000_B505));
    send_beat(node_at(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_beat(node_at(-64'sd2147483648, -64'sd2147483648));
    send_beat(edge_of(0, 1));
    send_beat(edge_of(0, 2));
    send_beat(edge_of(6, 5));

    write_tolerance(TOL_W'(32'h7FFF_FFFF));
    send_beat(noise_beat(KIND_CLEAR));
    send_beat(node_at(32'h7FFF_FFFF, 0));
    send_beat(node_at(-64'sd2147483648, 0));
    calm = 1;
    for (int n = 0; n < NODE_CAP - 2; n++)
      send_beat(node_at(jitter() >>> 4, jitter() >>> 4));
    send_beat(node_at(0, 0));
    send_beat(edge_of(1023, 0));
    calm = 0;

    run_phase('0, 30);
    run_phase(TOL_W'(1), 30);
    run_phase(TOL_W'(32'h7FFF_FFFF), 30);
    for (int p = 0; p < 2; p++)
      run_phase(TOL_W'($urandom_range(1, 32'h0100_0000)), 25);
    calm = 1;
    run_phase(TOL_W'($urandom), 40);
    calm = 0;
    run_phase(TOL_W'($urandom), 30);

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d result beats: %0d merged nodes, %0d rejected items, %0d kept edges.",
             sb.beats_seen, sb.merges, sb.rejects, sb.edges_kept);
    $display("Tolerances from zero to full scale, store filled to capacity, clears mid-stream.");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
